// ----- src/stg_pkg.sv -----
// ============================================================================
// stg_pkg
// Shared types, widths and constants of the swing trajectory generator.
// ============================================================================
package stg_pkg;

    localparam int IN_W        = 11;   // target coordinate width
    localparam int OUT_W       = 19;   // point coordinate width, 8 fraction bits
    localparam int IDX_OUT_W   = 6;    // point_index width
    localparam int SQ_W        = 21;   // one squared coordinate
    localparam int SQ_N_W      = 22;   // sum of squares / root remainder
    localparam int SQ_S_W      = 23;   // root partial value and trial
    localparam int SQRT_STAGES = 11;   // one root bit per stage
    localparam int LEN_W       = 11;   // rounded length
    localparam int C3_W        = 27;   // 3 * 0.3 * len in Q16
    localparam int S_W         = 18;   // Q16 fraction, up to 1.0
    localparam int SZ_W        = 16;   // Q16 fraction of the swing, below 1.0
    localparam int TWO_Q16     = 131072;

    localparam logic [15:0]            C03_X3 = 16'd58983;   // 3 * round(0.3 * 2^16)
    localparam logic [16:0]            Q_ONE  = 17'h10000;
    localparam logic signed [29:0]     XY_RND = 30'sd128;
    localparam logic signed [61:0]     Z_RND  = 62'sh80_0000_0000;
    localparam logic signed [21:0]     SAT_HI = 22'sd262143;
    localparam logic signed [21:0]     SAT_LO = -22'sd262144;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } target_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [21:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = OUT_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = OUT_MIN;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/stg_in_if.sv -----
// ============================================================================
// stg_in_if
// Target channel: valid/ready handshake carrying one integer foot target.
// ============================================================================
interface stg_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [stg_pkg::IN_W-1:0]   target_x;
    logic signed [stg_pkg::IN_W-1:0]   target_y;
    logic signed [stg_pkg::IN_W-1:0]   target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

// ----- src/stg_out_if.sv -----
// ============================================================================
// stg_out_if
// Point channel: valid/ready handshake carrying one trajectory point.
// ============================================================================
interface stg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [stg_pkg::IDX_OUT_W-1:0]        point_index;
    logic signed [stg_pkg::OUT_W-1:0]     point_x;
    logic signed [stg_pkg::OUT_W-1:0]     point_y;
    logic signed [stg_pkg::OUT_W-1:0]     point_z;
    logic                                 last;

    modport source (output valid, output point_index, output point_x, output point_y,
                    output point_z, output last, input ready);
    modport sink   (input valid, input point_index, input point_x, input point_y,
                    input point_z, input last, output ready);
endinterface

// ----- src/step_trajectory_generator.sv -----
// ============================================================================
// step_trajectory_generator: a target passes the square, sum, root, round and
// scale registers to the point sequencer, which issues STEPS+1 points per target,
// one point a cycle unless the 6-stage datapath stalls; point.ready holds the flow.
// Reset (rst_n, async) clears valid bits and the sequencer; data registers keep X.
// ============================================================================
module step_trajectory_generator #(
    parameter int STEPS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    stg_in_if.sink     target,
    stg_out_if.source  point
);

    localparam int H     = STEPS / 2;
    localparam int H2    = 2 * H;
    localparam int IDX_W = $clog2(STEPS + 1);
    localparam int NQ    = stg_pkg::SQRT_STAGES;

    // ------------------------------------------------------------------
    // Front end: squares, sum, pipelined root
    // ------------------------------------------------------------------
    logic                         f1_v_reg, f2_v_reg;
    logic                         f1_rdy, f2_rdy;
    stg_pkg::target_t             f1_tgt_reg, f2_tgt_reg;
    logic [stg_pkg::SQ_W-1:0]     f1_sqx_reg, f1_sqy_reg, f1_sqz_reg;
    logic [stg_pkg::SQ_W-1:0]     sqx_next, sqy_next, sqz_next;
    logic [stg_pkg::SQ_N_W-1:0]   f2_n_reg;

    always_comb
    begin
        logic signed [21:0] px, py, pz;
        px = target.target_x * target.target_x;
        py = target.target_y * target.target_y;
        pz = target.target_z * target.target_z;
        sqx_next = px[stg_pkg::SQ_W-1:0];
        sqy_next = py[stg_pkg::SQ_W-1:0];
        sqz_next = pz[stg_pkg::SQ_W-1:0];
    end

    logic                        sq_v_reg  [1:NQ];
    logic [stg_pkg::SQ_N_W-1:0]  sq_n_reg  [1:NQ];
    logic [stg_pkg::SQ_S_W-1:0]  sq_s_reg  [1:NQ];
    stg_pkg::target_t            sq_t_reg  [1:NQ];
    logic                        sq_in_v   [1:NQ];
    logic [stg_pkg::SQ_N_W-1:0]  sq_in_n   [1:NQ];
    logic [stg_pkg::SQ_S_W-1:0]  sq_in_s   [1:NQ];
    stg_pkg::target_t            sq_in_t   [1:NQ];
    logic                        sq_rdy    [1:NQ+1];

    logic                        r1_v_reg, r2_v_reg, r1_rdy, r2_rdy;
    logic [stg_pkg::LEN_W-1:0]   r1_len_reg;
    stg_pkg::target_t            r1_tgt_reg, r2_tgt_reg;
    logic [stg_pkg::C3_W-1:0]    r2_c3_reg;

    assign f2_rdy       = !f2_v_reg || sq_rdy[1];
    assign f1_rdy       = !f1_v_reg || f2_rdy;
    assign target.ready = f1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_rdy)
            begin
                f1_v_reg <= target.valid;
            end
            if (f2_rdy)
            begin
                f2_v_reg <= f1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_rdy && target.valid)
        begin
            f1_tgt_reg <= '{x: target.target_x, y: target.target_y, z: target.target_z};
            f1_sqx_reg <= sqx_next;
            f1_sqy_reg <= sqy_next;
            f1_sqz_reg <= sqz_next;
        end
        if (f2_rdy && f1_v_reg)
        begin
            f2_tgt_reg <= f1_tgt_reg;
            f2_n_reg   <= {1'b0, f1_sqx_reg} + {1'b0, f1_sqy_reg} + {1'b0, f1_sqz_reg};
        end
    end

    // digit-by-digit root, stage k tries bit 4^(NQ-k)
    for (genvar k = 1; k <= NQ; k++)
    begin : g_sqrt
        localparam logic [stg_pkg::SQ_S_W-1:0] B =
            stg_pkg::SQ_S_W'(1) << (2 * (NQ - k));
        logic [stg_pkg::SQ_S_W-1:0] trial;
        logic [stg_pkg::SQ_N_W-1:0] n_next;
        logic [stg_pkg::SQ_S_W-1:0] s_next;

        if (k == 1)
        begin : g_first
            assign sq_in_v[k] = f2_v_reg;
            assign sq_in_n[k] = f2_n_reg;
            assign sq_in_s[k] = '0;
            assign sq_in_t[k] = f2_tgt_reg;
        end
        else
        begin : g_rest
            assign sq_in_v[k] = sq_v_reg[k-1];
            assign sq_in_n[k] = sq_n_reg[k-1];
            assign sq_in_s[k] = sq_s_reg[k-1];
            assign sq_in_t[k] = sq_t_reg[k-1];
        end

        assign sq_rdy[k] = !sq_v_reg[k] || sq_rdy[k+1];

        always_comb
        begin
            trial = sq_in_s[k] + B;
            if ({1'b0, sq_in_n[k]} >= trial)
            begin
                n_next = sq_in_n[k] - trial[stg_pkg::SQ_N_W-1:0];
                s_next = (sq_in_s[k] >> 1) + B;
            end
            else
            begin
                n_next = sq_in_n[k];
                s_next = sq_in_s[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (sq_rdy[k])
            begin
                sq_v_reg[k] <= sq_in_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (sq_rdy[k] && sq_in_v[k])
            begin
                sq_n_reg[k] <= n_next;
                sq_s_reg[k] <= s_next;
                sq_t_reg[k] <= sq_in_t[k];
            end
        end
    end

    assign sq_rdy[NQ+1] = r1_rdy;

    // ------------------------------------------------------------------
    // Round the root, scale by 3 * 0.3
    // ------------------------------------------------------------------
    logic iss_take;

    assign r2_rdy = !r2_v_reg || iss_take;
    assign r1_rdy = !r1_v_reg || r2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_v_reg <= 1'b0;
            r2_v_reg <= 1'b0;
        end
        else
        begin
            if (r1_rdy)
            begin
                r1_v_reg <= sq_v_reg[NQ];
            end
            if (r2_rdy)
            begin
                r2_v_reg <= r1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1_rdy && sq_v_reg[NQ])
        begin
            // remainder above the root means the true root is past the half point
            r1_len_reg <= sq_s_reg[NQ][stg_pkg::LEN_W-1:0]
                        + stg_pkg::LEN_W'({1'b0, sq_n_reg[NQ]} > sq_s_reg[NQ]);
            r1_tgt_reg <= sq_t_reg[NQ];
        end
        if (r2_rdy && r1_v_reg)
        begin
            r2_c3_reg  <= r1_len_reg * stg_pkg::C03_X3;
            r2_tgt_reg <= r1_tgt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Point sequencer
    // ------------------------------------------------------------------
    logic [stg_pkg::S_W-1:0]  sxy_tab [STEPS+1];
    logic [stg_pkg::SZ_W-1:0] sz_tab  [STEPS+1];

    for (genvar g = 0; g <= STEPS; g++)
    begin : g_tab
        localparam int unsigned KN    = (g < H) ? g : ((g < STEPS) ? STEPS - g : 0);
        localparam int unsigned S_VAL = (KN * stg_pkg::TWO_Q16 + H) / H2;
        assign sxy_tab[g] = stg_pkg::S_W'(S_VAL);
        assign sz_tab[g]  = (g < H) ? stg_pkg::SZ_W'(S_VAL) : '0;
    end

    logic                      iss_busy_reg;
    logic [IDX_W-1:0]          iss_idx_reg;
    stg_pkg::target_t          iss_tgt_reg;
    logic [stg_pkg::C3_W-1:0]  iss_c3_reg;
    logic                      iss_fire, iss_end;
    logic                      s1_rdy;

    assign iss_end  = iss_idx_reg == IDX_W'(STEPS);
    assign iss_fire = iss_busy_reg && s1_rdy;
    assign iss_take = !iss_busy_reg || (iss_fire && iss_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_busy_reg <= 1'b0;
            iss_idx_reg  <= '0;
        end
        else if (iss_take)
        begin
            iss_busy_reg <= r2_v_reg;
            iss_idx_reg  <= '0;
        end
        else if (iss_fire)
        begin
            iss_idx_reg <= iss_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_take && r2_v_reg)
        begin
            iss_tgt_reg <= r2_tgt_reg;
            iss_c3_reg  <= r2_c3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Point datapath S1..S6
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;

    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg, s6_idx_reg;
    logic             s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg, s5_last_reg;
    logic             s6_last_reg;

    logic [stg_pkg::S_W-1:0]          s1_sxy_reg;
    logic [stg_pkg::SZ_W-1:0]         s1_sz_reg, s2_sz_reg, s3_sz_reg;
    stg_pkg::target_t                 s1_tgt_reg;
    logic signed [stg_pkg::IN_W-1:0]  s2_tz_reg;
    logic [stg_pkg::C3_W-1:0]         s1_c3_reg, s2_c3_reg;
    logic signed [29:0]               s2_xp_reg, s2_yp_reg;
    logic [31:0]                      s2_ss_reg;
    logic [30:0]                      s2_ssp_reg;
    logic signed [stg_pkg::OUT_W-1:0] s3_x_reg, s3_y_reg, s4_x_reg, s4_y_reg;
    logic signed [stg_pkg::OUT_W-1:0] s5_x_reg, s5_y_reg, s6_x_reg, s6_y_reg, s6_z_reg;
    logic signed [43:0]               s3_sst_reg;
    logic [57:0]                      s3_a_reg, s4_a_reg;
    logic signed [60:0]               s4_b_reg;
    logic signed [61:0]               s5_zsum_reg;

    logic [16:0]        sp_next;
    logic [32:0]        ssp_next;
    logic signed [29:0] xr_next, yr_next;

    always_comb
    begin
        sp_next  = stg_pkg::Q_ONE - {1'b0, s1_sz_reg};
        ssp_next = {1'b0, s1_sz_reg} * sp_next;
        xr_next  = s2_xp_reg + stg_pkg::XY_RND;
        yr_next  = s2_yp_reg + stg_pkg::XY_RND;
    end

    assign s6_rdy = !s6_v_reg || point.ready;
    assign s5_rdy = !s5_v_reg || s6_rdy;
    assign s4_rdy = !s4_v_reg || s5_rdy;
    assign s3_rdy = !s3_v_reg || s4_rdy;
    assign s2_rdy = !s2_v_reg || s3_rdy;
    assign s1_rdy = !s1_v_reg || s2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_v_reg <= iss_busy_reg;
            if (s2_rdy) s2_v_reg <= s1_v_reg;
            if (s3_rdy) s3_v_reg <= s2_v_reg;
            if (s4_rdy) s4_v_reg <= s3_v_reg;
            if (s5_rdy) s5_v_reg <= s4_v_reg;
            if (s6_rdy) s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_fire)
        begin
            s1_idx_reg  <= iss_idx_reg;
            s1_last_reg <= iss_end;
            s1_sxy_reg  <= sxy_tab[iss_idx_reg];
            s1_sz_reg   <= sz_tab[iss_idx_reg];
            s1_tgt_reg  <= iss_tgt_reg;
            s1_c3_reg   <= iss_c3_reg;
        end
        if (s2_rdy && s1_v_reg)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
            s2_xp_reg   <= $signed({1'b0, s1_sxy_reg}) * s1_tgt_reg.x;
            s2_yp_reg   <= $signed({1'b0, s1_sxy_reg}) * s1_tgt_reg.y;
            s2_ss_reg   <= s1_sz_reg * s1_sz_reg;
            s2_ssp_reg  <= ssp_next[30:0];
            s2_sz_reg   <= s1_sz_reg;
            s2_tz_reg   <= s1_tgt_reg.z;
            s2_c3_reg   <= s1_c3_reg;
        end
        if (s3_rdy && s2_v_reg)
        begin
            s3_idx_reg  <= s2_idx_reg;
            s3_last_reg <= s2_last_reg;
            s3_x_reg    <= stg_pkg::sat_out($signed(xr_next[29:8]));
            s3_y_reg    <= stg_pkg::sat_out($signed(yr_next[29:8]));
            s3_sst_reg  <= $signed({1'b0, s2_ss_reg}) * s2_tz_reg;
            s3_a_reg    <= s2_ssp_reg * s2_c3_reg;
            s3_sz_reg   <= s2_sz_reg;
        end
        if (s4_rdy && s3_v_reg)
        begin
            s4_idx_reg  <= s3_idx_reg;
            s4_last_reg <= s3_last_reg;
            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_b_reg    <= s3_sst_reg * $signed({1'b0, s3_sz_reg});
            s4_a_reg    <= s3_a_reg;
        end
        if (s5_rdy && s4_v_reg)
        begin
            s5_idx_reg  <= s4_idx_reg;
            s5_last_reg <= s4_last_reg;
            s5_x_reg    <= s4_x_reg;
            s5_y_reg    <= s4_y_reg;
            // Q48 sum plus half an output LSB
            s5_zsum_reg <= $signed({4'b0000, s4_a_reg}) + {s4_b_reg[60], s4_b_reg}
                         + stg_pkg::Z_RND;
        end
        if (s6_rdy && s5_v_reg)
        begin
            s6_idx_reg  <= s5_idx_reg;
            s6_last_reg <= s5_last_reg;
            s6_x_reg    <= s5_x_reg;
            s6_y_reg    <= s5_y_reg;
            s6_z_reg    <= stg_pkg::sat_out($signed(s5_zsum_reg[61:40]));
        end
    end

    assign point.valid       = s6_v_reg;
    assign point.point_index = stg_pkg::IDX_OUT_W'(s6_idx_reg);
    assign point.point_x     = s6_x_reg;
    assign point.point_y     = s6_y_reg;
    assign point.point_z     = s6_z_reg;
    assign point.last        = s6_last_reg;

endmodule

// ----- src/stg_checker.sv -----
// ============================================================================
// stg_checker
// Port-level checks of the point stream, bound to the top level.
// ============================================================================
module stg_checker #(
    parameter int STEPS = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [stg_pkg::IDX_OUT_W-1:0]       point_index,
    input logic signed [stg_pkg::OUT_W-1:0]    point_x,
    input logic signed [stg_pkg::OUT_W-1:0]    point_y,
    input logic signed [stg_pkg::OUT_W-1:0]    point_z,
    input logic                                last
);

    localparam int H = STEPS / 2;

    logic [stg_pkg::IDX_OUT_W-1:0] exp_idx_reg;
    logic [7:0]                    pend_reg;
    logic                          in_xfer, out_xfer, run_done;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign run_done = out_xfer && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (out_xfer)
            begin
                exp_idx_reg <= last ? '0 : point_index + 1'b1;
            end
            pend_reg <= pend_reg + 8'(in_xfer) - 8'(run_done);
        end
    end

    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_index == exp_idx_reg)
        else $error("point index out of sequence");

    a_last_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |->
            point_index == stg_pkg::IDX_OUT_W'(STEPS) && point_x == '0 && point_y == '0)
        else $error("last point is not the origin at index STEPS");

    a_return_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_index >= stg_pkg::IDX_OUT_W'(H) |-> point_z == '0)
        else $error("z not zero on the return path");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("point shown with no target outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_index)
            && $stable(point_x) && $stable(point_y) && $stable(point_z) && $stable(last))
        else $error("stalled point changed");

endmodule

bind step_trajectory_generator stg_checker #(.STEPS(STEPS)) u_stg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (target.valid),
    .in_ready    (target.ready),
    .out_valid   (point.valid),
    .out_ready   (point.ready),
    .point_index (point.point_index),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_z     (point.point_z),
    .last        (point.last)
);
